### design/asl_pkg.sv
package asl_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] K_WORD   = 3'd0;
  localparam logic [2:0] K_INT    = 3'd1;
  localparam logic [2:0] K_FLOAT  = 3'd2;
  localparam logic [2:0] K_CHAR   = 3'd3;
  localparam logic [2:0] K_STRING = 3'd4;
  localparam logic [2:0] K_SYMBOL = 3'd5;
  localparam logic [2:0] K_END    = 3'd6;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     tok;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB;
  endfunction

endpackage

### design/asl_byte_if.sv
interface asl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       final_byte;

  modport source (output valid, output source_byte, output final_byte, input ready);
  modport sink (input valid, input source_byte, input final_byte, output ready);
endinterface

### design/asl_token_if.sv
interface asl_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input run_last, output ready);
endinterface

### design/asl_front.sv
module asl_front
  import asl_pkg::*;
#(
  parameter logic [15:0] POS_LIMIT = 16'hFFFF
) (
  input  logic      clk,
  input  logic      rst,
  asl_byte_if.sink  src,
  input  logic      push_ready,
  output logic      push_valid,
  output bundle_t   push_data
);

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUM, M_CHAR, M_CHAR_CLOSE, M_STR, M_STR_ESC
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] byte_position;
  logic [15:0] token_begin, token_begin_next;
  logic        seen_dot, seen_dot_next;

  logic [7:0]  c;
  logic        fin;
  logic        used;
  logic [1:0]  n;
  token_t [2:0] slot;
  logic [15:0] pos_inc;
  logic [16:0] end_pos;
  logic        accept;

  function automatic logic [15:0] span(input logic [15:0] from, input logic [16:0] to);
    logic [16:0] d;
    d = to - {1'b0, from};
    if (to <= {1'b0, from}) return 16'd0;
    if (d[16]) return 16'hFFFF;
    return d[15:0];
  endfunction

  function automatic token_t mk(input logic [2:0] k, input logic [15:0] s,
                                input logic [15:0] l);
    token_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    return t;
  endfunction

  always_comb begin
    c                = src.source_byte;
    fin              = src.final_byte;
    pos_inc          = (byte_position < POS_LIMIT) ? byte_position + 16'd1 : byte_position;
    end_pos          = {1'b0, byte_position} + 17'd1;
    used             = 1'b0;
    n                = 2'd0;
    slot             = '0;
    mode_next        = mode;
    token_begin_next = token_begin;
    seen_dot_next    = seen_dot;

    case (mode)
      M_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
          used = 1'b1;
        end else begin
          slot[n] = mk(K_WORD, token_begin, span(token_begin, {1'b0, byte_position}));
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          used = 1'b1;
        end else if (c == CH_DOT) begin
          seen_dot_next = 1'b1;
          used = 1'b1;
        end else begin
          slot[n] = mk(seen_dot ? K_FLOAT : K_INT, token_begin,
                       span(token_begin, {1'b0, byte_position}));
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_CHAR: begin
        token_begin_next = byte_position;
        mode_next = M_CHAR_CLOSE;
        used = 1'b1;
      end
      M_CHAR_CLOSE: begin
        slot[n] = mk(K_CHAR, token_begin, 16'd1);
        n = n + 2'd1;
        mode_next = M_IDLE;
        used = 1'b1;
      end
      M_STR: begin
        if (c == CH_BACKSLASH) begin
          mode_next = M_STR_ESC;
        end else if (c == CH_DQUOTE) begin
          slot[n] = mk(K_STRING, token_begin, span(token_begin, {1'b0, byte_position}));
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
        used = 1'b1;
      end
      M_STR_ESC: begin
        mode_next = M_STR;
        used = 1'b1;
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    if (!used) begin
      if (is_space(c)) begin
        mode_next = mode_next;
      end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
        token_begin_next = byte_position;
        mode_next = M_WORD;
      end else if (is_digit(c)) begin
        token_begin_next = byte_position;
        seen_dot_next = 1'b0;
        mode_next = M_NUM;
      end else if (c == CH_QUOTE) begin
        token_begin_next = pos_inc;
        mode_next = M_CHAR;
      end else if (c == CH_DQUOTE) begin
        token_begin_next = pos_inc;
        mode_next = M_STR;
      end else begin
        slot[n] = mk(K_SYMBOL, byte_position, 16'd1);
        n = n + 2'd1;
      end
    end

    if (fin) begin
      case (mode_next)
        M_WORD: begin
          slot[n] = mk(K_WORD, token_begin_next, span(token_begin_next, end_pos));
          n = n + 2'd1;
        end
        M_NUM: begin
          slot[n] = mk(seen_dot_next ? K_FLOAT : K_INT, token_begin_next,
                       span(token_begin_next, end_pos));
          n = n + 2'd1;
        end
        M_CHAR, M_CHAR_CLOSE: begin
          slot[n] = mk(K_CHAR, token_begin_next, 16'd1);
          n = n + 2'd1;
        end
        M_STR, M_STR_ESC: begin
          slot[n] = mk(K_STRING, token_begin_next, span(token_begin_next, end_pos));
          n = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      slot[n] = mk(K_END, 16'd0, 16'd0);
      n = n + 2'd1;
    end
  end

  assign accept     = src.valid && push_ready;
  assign src.ready  = push_ready;
  assign push_valid = accept && (n != 2'd0);
  assign push_data  = '{count: n, tok: slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      byte_position <= 16'd0;
      token_begin   <= 16'd0;
      seen_dot      <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        mode          <= M_IDLE;
        byte_position <= 16'd0;
        token_begin   <= 16'd0;
        seen_dot      <= 1'b0;
      end else begin
        mode          <= mode_next;
        byte_position <= pos_inc;
        token_begin   <= token_begin_next;
        seen_dot      <= seen_dot_next;
      end
    end
  end

endmodule

### design/asl_queue.sv
module asl_queue
  import asl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  bundle_t push_data,
  output logic    push_ready,
  output logic    pop_valid,
  output bundle_t pop_data,
  input  logic    pop_ready
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  bundle_t       entry [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

### design/asl_back.sv
module asl_back
  import asl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  input  bundle_t     pop_data,
  output logic        pop_ready,
  asl_token_if.source tok
);

  logic    held;
  bundle_t cur;
  logic [1:0] idx;
  logic    last, advance;

  assign last     = idx == (cur.count - 2'd1);
  assign advance  = held && tok.ready;
  assign pop_ready = !held || (advance && last);

  assign tok.valid        = held;
  assign tok.token_kind   = cur.tok[idx].kind;
  assign tok.token_start  = cur.tok[idx].start;
  assign tok.token_length = cur.tok[idx].length;
  assign tok.run_last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else if (pop_valid && pop_ready) begin
      held <= 1'b1;
      cur  <= pop_data;
      idx  <= 2'd0;
    end else if (advance) begin
      if (last) held <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

endmodule

### design/assembler_source_lexer_unit.sv
// The tokens of a byte are registered in the token queue and then in the output register
// before they are offered on tok.
// Throughput: one source byte per cycle while the 4-entry token queue has room;
// tokens leave one per cycle while tok.ready is high; a byte can yield up to three tokens.
// Bytes that yield no token (separators, token bodies) use no output cycle.
// Reset (rst, synchronous): lexer idle at offset zero, queue and output register empty.
module assembler_source_lexer_unit
  import asl_pkg::*;
#(
  parameter longint unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  asl_byte_if.sink    src,
  asl_token_if.source tok
);

  localparam logic [15:0] POS_LIMIT =
    (MAX_SOURCE_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_SOURCE_BYTES - 1);

  logic    push_valid, push_ready, pop_valid, pop_ready;
  bundle_t push_data, pop_data;

  asl_front #(.POS_LIMIT(POS_LIMIT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  asl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  asl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .tok       (tok)
  );

  a_final_pushes: assert property (@(posedge clk) disable iff (rst)
    src.valid && src.ready && src.final_byte |-> push_valid)
    else $error("final byte produced no token bundle");

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_data.count != 2'd0)
    else $error("empty token bundle pushed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.token_kind == K_END |-> tok.run_last)
    else $error("end token not last of its byte");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    !pop_valid |=> !tok.valid || $past(tok.valid))
    else $error("output appeared with an empty queue");

endmodule
